FILE: design/kpvf_pkg.sv
// ----------------------------------------------------------------------------
// kpvf_pkg
// Shared types, constants and the saturation helper for the two-state constant-velocity filter.
// ----------------------------------------------------------------------------
`default_nettype none
package kpvf_pkg;
  localparam int FracBitsDefault = 16;
  localparam logic [30:0] StepIntervalReset = 31'd262144;
  localparam logic [30:0] NoisePosReset     = 31'd66;
  localparam logic [30:0] NoiseVelReset     = 31'd66;
  localparam logic [30:0] MeasNoiseReset    = 31'd131072;

  localparam logic [1:0] RegStep  = 2'd0;
  localparam logic [1:0] RegQPos  = 2'd1;
  localparam logic [1:0] RegQVel  = 2'd2;
  localparam logic [1:0] RegRMeas = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_M_DTV, S_A_XP,
    S_M_DTP11, S_A_P01,
    S_M_DTP01O, S_A_P00A,
    S_M_DTP01, S_A_P00B, S_A_P00Q, S_A_P11, S_A_S,
    S_D_K0, S_W_K0, S_D_K1, S_W_K1,
    S_SUB_Y,
    S_M_K0Y, S_A_X,
    S_M_K1Y, S_A_V,
    S_M_K0P00, S_SUB_P00,
    S_M_K0P01, S_SUB_P01,
    S_M_K1P01, S_SUB_P11,
    S_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction
endpackage
`default_nettype wire

FILE: design/kalman_position_velocity_filter_unit.sv
// ----------------------------------------------------------------------------
// kalman_position_velocity_filter_unit
// Two-state constant-velocity Kalman filter on a position stream.
// ----------------------------------------------------------------------------
// One measurement transaction yields one filtered position. A sequencer
// drives one shared 32x32 multiplier and one saturating adder, plus a
// bit-serial divider for the two gains. Input stall is high from acceptance
// until the result has been taken.
`default_nettype none
module kalman_position_velocity_filter_unit import kpvf_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] measurement,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      filtered_position
);
  logic [30:0] dt, qp, qv, rm;
  logic signed [31:0] x, v, p00, p01, p11;
  logic signed [31:0] z, xp, tp01, tp00, tp11, s, k0, k1, y, acc;
  logic signed [31:0] ma, mb, aa, ab, prod;
  logic signed [63:0] praw;
  logic [63:0] pm;
  logic        asub;
  logic signed [31:0] asum;
  state_t state, state_next;
  logic div_start, div_done;
  logic signed [31:0] dnum, quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= StepIntervalReset; qp <= NoisePosReset;
      qv <= NoiseVelReset;     rm <= MeasNoiseReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegStep:  dt <= cfg_data;
        RegQPos:  qp <= cfg_data;
        RegQVel:  qv <= cfg_data;
        RegRMeas: rm <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared rounded multiplier
  always_comb begin
    praw = ma * mb;
    pm   = praw[63] ? 64'(-praw) : 64'(praw);
    pm   = (pm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    prod = sat32(praw[63] ? -$signed(66'(pm)) : $signed(66'(pm)));
  end

  // shared saturating adder
  assign asum = sat32(asub ? 66'(aa) - 66'(ab) : 66'(aa) + 66'(ab));

  kpvf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dnum), .den(s),
    .done(div_done), .quo(quo));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_M_DTV;
      S_D_K0:     state_next = S_W_K0;
      S_W_K0:     if (div_done) state_next = S_D_K1;
      S_D_K1:     state_next = S_W_K1;
      S_W_K1:     if (div_done) state_next = S_SUB_Y;
      S_OUT:      if (!out_stall) state_next = S_IDLE;
      default:    state_next = state_t'(state + 1'b1);
    endcase
  end

  // operand selection
  always_comb begin
    ma = '0; mb = '0; aa = '0; ab = '0; asub = 1'b0;
    div_start = 1'b0; dnum = tp00;
    unique case (state)
      S_M_DTV:    begin ma = $signed({1'b0, dt}); mb = v;   end
      S_A_XP:     begin aa = x;   ab = acc; end
      S_M_DTP11:  begin ma = $signed({1'b0, dt}); mb = p11; end
      S_A_P01:    begin aa = p01; ab = acc; end
      S_M_DTP01O: begin ma = $signed({1'b0, dt}); mb = p01; end
      S_A_P00A:   begin aa = p00; ab = acc; end
      S_M_DTP01:  begin ma = $signed({1'b0, dt}); mb = tp01; end
      S_A_P00B:   begin aa = tp00; ab = acc; end
      S_A_P00Q:   begin aa = tp00; ab = $signed({1'b0, qp}); end
      S_A_P11:    begin aa = p11; ab = $signed({1'b0, qv}); end
      S_A_S:      begin aa = tp00; ab = $signed({1'b0, rm}); end
      S_D_K0:     begin div_start = 1'b1; dnum = tp00; end
      S_D_K1:     begin div_start = 1'b1; dnum = tp01; end
      S_SUB_Y:    begin aa = z; ab = xp; asub = 1'b1; end
      S_M_K0Y:    begin ma = k0; mb = y; end
      S_A_X:      begin aa = xp; ab = acc; end
      S_M_K1Y:    begin ma = k1; mb = y; end
      S_A_V:      begin aa = v; ab = acc; end
      S_M_K0P00:  begin ma = k0; mb = tp00; end
      S_SUB_P00:  begin aa = tp00; ab = acc; asub = 1'b1; end
      S_M_K0P01:  begin ma = k0; mb = tp01; end
      S_SUB_P01:  begin aa = tp01; ab = acc; asub = 1'b1; end
      S_M_K1P01:  begin ma = k1; mb = tp01; end
      S_SUB_P11:  begin aa = tp11; ab = acc; asub = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0; v <= '0; p01 <= '0;
      p00 <= 32'sd1 <<< FRAC_BITS;
      p11 <= 32'sd1 <<< FRAC_BITS;
    end else begin
      unique case (state)
        S_IDLE:     if (in_valid) z <= measurement;
        S_A_XP:     xp <= asum;
        S_A_P01:    tp01 <= asum;
        S_A_P00A:   tp00 <= asum;
        S_A_P00B:   tp00 <= asum;
        S_A_P00Q:   tp00 <= asum;
        S_A_P11:    tp11 <= asum;
        S_A_S:      s <= asum;
        S_W_K0:     if (div_done) k0 <= quo;
        S_W_K1:     if (div_done) k1 <= quo;
        S_SUB_Y:    y <= asum;
        S_A_X:      x <= asum;
        S_A_V:      v <= asum;
        S_SUB_P00:  p00 <= asum;
        S_SUB_P01:  p01 <= asum;
        S_SUB_P11:  p11 <= asum;
        default: ;
      endcase
      acc <= prod;
    end
  end

  assign in_stall          = (state != S_IDLE);
  assign out_valid         = (state == S_OUT);
  assign filtered_position = x;
endmodule
`default_nettype wire

FILE: design/kpvf_div.sv
// ----------------------------------------------------------------------------
// kpvf_div
// Iterative rounded fixed-point divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module kpvf_div import kpvf_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  localparam int NW = 32 + FRAC_BITS;  // numerator magnitude width
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]  rem_n;   // shifting numerator
  logic [32:0]    rem;
  logic [NW-1:0]  q;
  logic [32:0]    ub;
  logic [32:0]    num_mag;
  logic           neg, zero_den, busy;
  logic [CW-1:0]  cnt;
  logic [33:0]    trial;
  logic [NW:0]    qr;
  logic signed [65:0] sq;

  assign num_mag = num[31] ? -33'(num) : 33'(num);

  assign trial = {rem[32:0], rem_n[NW-1]} - {1'b0, ub};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg      <= num[31] ^ den[31];
      zero_den <= (den == '0);
      rem_n    <= NW'(num_mag) << FRAC_BITS;
      ub       <= den[31] ? -{den[31], den} : {den[31], den};
      rem      <= '0;
      q        <= '0;
    end else if (busy) begin
      rem_n <= rem_n << 1;
      if (!trial[33]) begin
        rem <= trial[32:0];
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[31:0], rem_n[NW-1]};
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end

  // round to nearest: bump when 2*rem >= ub (ub/2 floored, matches +ub/2)
  always_comb begin
    qr = {1'b0, q} + ((({rem, 1'b0} >= ({1'b0, ub} + {33'd0, ub[0]}))) ? 1'b1 : 1'b0);
    sq = neg ? -$signed(66'(qr)) : $signed(66'(qr));
    quo = zero_den ? '0 : sat32(sq);
  end
endmodule
`default_nettype wire

FILE: sim/kalman_position_velocity_filter_unit_test.sv
// ----------------------------------------------------------------------------
// kalman_position_velocity_filter_unit_test
// Drives measurements and register writes into the position/velocity filter
// and checks every filtered position against a fixed-point Q16.16 predictor.
// ----------------------------------------------------------------------------
`default_nettype none

class kpvf_scoreboard;
  int fx;
  logic signed [31:0] dt, q_pos, q_vel, r_meas;
  logic signed [31:0] x_est, v_est, p00_st, p01_st, p11_st;
  logic signed [31:0] pos_queue[$];
  int n_checked;

  function new(int frac);
    fx = frac;
    n_checked = 0;
    dt = 32'sd262144;
    q_pos = 32'sd66;
    q_vel = 32'sd66;
    r_meas = 32'sd131072;
    x_est = 0;
    v_est = 0;
    p00_st = 32'sd1 <<< frac;
    p01_st = 0;
    p11_st = 32'sd1 <<< frac;
  endfunction

  function logic signed [31:0] clamp(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function logic signed [31:0] add_s(logic signed [31:0] a, logic signed [31:0] b);
    return clamp(longint'(a) + longint'(b));
  endfunction

  function logic signed [31:0] sub_s(logic signed [31:0] a, logic signed [31:0] b);
    return clamp(longint'(a) - longint'(b));
  endfunction

  function logic signed [31:0] mul_q(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    longint m;
    p = longint'(a) * longint'(b);
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 <<< (fx - 1))) >>> fx;
    return clamp((p < 0) ? -m : m);
  endfunction

  function logic signed [31:0] div_q(logic signed [31:0] a, logic signed [31:0] b);
    longint un;
    longint ub;
    longint q;
    if (b == 0) return 0;
    un = longint'(a) <<< fx;
    un = (un < 0) ? -un : un;
    ub = longint'(b);
    ub = (ub < 0) ? -ub : ub;
    q = (un + ub / 2) / ub;
    return clamp(((a < 0) != (b < 0)) ? -q : q);
  endfunction

  function void write_reg(logic [1:0] idx, logic [30:0] val);
    case (idx)
      kpvf_pkg::RegStep:  dt = {1'b0, val};
      kpvf_pkg::RegQPos:  q_pos = {1'b0, val};
      kpvf_pkg::RegQVel:  q_vel = {1'b0, val};
      kpvf_pkg::RegRMeas: r_meas = {1'b0, val};
      default: ;
    endcase
  endfunction

  // one filter step per accepted measurement transaction
  function void note_measurement(logic signed [31:0] z);
    logic signed [31:0] xp, p01, p00, p11, s, k0, k1, y;
    xp = add_s(x_est, mul_q(dt, v_est));
    p01 = add_s(p01_st, mul_q(dt, p11_st));
    p00 = add_s(add_s(p00_st, mul_q(dt, p01_st)), mul_q(dt, p01));
    p00 = add_s(p00, q_pos);
    p11 = add_s(p11_st, q_vel);
    s = add_s(p00, r_meas);
    k0 = div_q(p00, s);
    k1 = div_q(p01, s);
    y = sub_s(z, xp);
    x_est = add_s(xp, mul_q(k0, y));
    v_est = add_s(v_est, mul_q(k1, y));
    p00_st = sub_s(p00, mul_q(k0, p00));
    p01_st = sub_s(p01, mul_q(k0, p01));
    p11_st = sub_s(p11, mul_q(k1, p01));
    pos_queue.push_back(x_est);
  endfunction

  function bit check_position(logic signed [31:0] got, output string msg);
    logic signed [31:0] want;
    n_checked++;
    msg = "";
    if (pos_queue.size() == 0) begin
      msg = $sformatf("unexpected filtered_position %0d", got);
      return 1'b0;
    end
    want = pos_queue.pop_front();
    if (got !== want) begin
      msg = $sformatf("filtered_position got %0d want %0d", got, want);
      return 1'b0;
    end
    return 1'b1;
  endfunction
endclass

module kalman_position_velocity_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kpvf_pkg::*;

  localparam int FracBits = FracBitsDefault;
  localparam int DrainCycles = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] measurement = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] filtered_position;

  int idle_pct_in = 25;
  int idle_pct_out = 25;
  int hold_out = 0;
  int n_sent = 0;
  int n_mismatch = 0;
  string chk_msg;

  kpvf_scoreboard filter_pred;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  kalman_position_velocity_filter_unit #(.FRAC_BITS(FracBits)) u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .measurement(measurement), .out_valid(out_valid), .out_stall(out_stall),
    .filtered_position(filtered_position)
  );

  task automatic report_mismatch(string what);
    n_mismatch++;
    $display("MISMATCH: %s", what);
  endtask

  // receiver: random stall, plus long hold-off when hold_out is set
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (!filter_pred.check_position(filtered_position, chk_msg))
          report_mismatch(chk_msg);
      end
      if (hold_out > 0) begin
        out_stall <= 1'b1;
        hold_out <= hold_out - 1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct_out);
      end
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [30:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    filter_pred.write_reg(idx, val);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (filter_pred.pos_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_measurement(logic signed [31:0] z);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    measurement <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_pred.note_measurement(z);
    n_sent++;
  endtask

  function automatic logic signed [31:0] rand_meas();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(20 << FracBits)) - (10 <<< FracBits);
    endcase
  endfunction

  function automatic logic [30:0] rand_cfg(logic [1:0] idx);
    case ($urandom_range(4))
      0: return (idx == RegRMeas) ? 31'd1 : 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom());
      default: return 31'($urandom_range(8 << FracBits));
    endcase
  endfunction

  logic signed [31:0] corner_meas[8] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1,
                                         32'sh0001_0000, -32'sh0001_0000, 32'sh4000_0000};

  initial begin
    filter_pred = new(FracBits);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults first, then extreme measurements
    foreach (corner_meas[i]) send_measurement(corner_meas[i]);
    wait_drained();
    // zero innovation variance: P00 + R becomes zero only with saturation paths;
    // large dt and noise push saturation, R=1 and dt=0 are the low extremes
    write_cfg(RegStep, 31'd0);
    write_cfg(RegQPos, 31'd0);
    write_cfg(RegQVel, 31'd0);
    write_cfg(RegRMeas, 31'd1);
    for (int i = 0; i < 6; i++) send_measurement(corner_meas[i]);
    wait_drained();
    write_cfg(RegStep, 31'h7FFF_FFFF);
    write_cfg(RegQPos, 31'h7FFF_FFFF);
    write_cfg(RegQVel, 31'h7FFF_FFFF);
    write_cfg(RegRMeas, 31'h7FFF_FFFF);
    for (int i = 0; i < 8; i++) send_measurement(corner_meas[i]);
    wait_drained();

    // random phases with new settings between them
    for (int ph = 0; ph < 12; ph++) begin
      for (int r = 0; r < 4; r++) write_cfg(r[1:0], rand_cfg(r[1:0]));
      if (ph == 3) begin
        idle_pct_in = 0;
        idle_pct_out = 0;
      end else begin
        idle_pct_in = 25;
        idle_pct_out = 25;
      end
      if (ph == 5) hold_out = 2000;
      for (int i = 0; i < 77; i++) send_measurement(rand_meas());
      wait_drained();
    end

    $display("Covered %0d measurements over 15 register settings incl. extremes,", n_sent);
    $display("with random stalls, a long output hold-off and drained pauses.");
    if (n_mismatch == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end
endmodule

`default_nettype wire
